### rtl/core/gds_pkg.sv
// Shared types and constants for the graph degree sequence unit.
// No dependencies; used by gds_cell and graph_degree_sequence_unit.
package gds_pkg;

	localparam int VTX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int DATA_W = 16;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_EDGE,
		CM_PAD,
		CM_SORT,
		CM_SHIFT,
		CM_CLEAR
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t             mode;
		logic [VTX_W-1:0]       vtx_a;
		logic [VTX_W-1:0]       vtx_b;
		logic                   directed;
		logic [CNT_W-1:0]       active;
		logic                   phase_odd;
	} cell_ctrl_t;

endpackage

### rtl/core/gds_cell.sv
// One vertex cell: degree counter plus pad flag, compare-exchange with neighbours.
// Depends on gds_pkg.
module gds_cell import gds_pkg::*; #(
	parameter int IDX       = 0,
	parameter int CELLS     = 32,
	parameter int DEG_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctrl_t          ctrl,
	input  logic [DEG_BITS:0]   left_key,
	input  logic [DEG_BITS:0]   right_key,
	output logic [DEG_BITS:0]   key
);

	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic             IDX_ODD = (IDX % 2) == 1;
	localparam bit               HAS_L  = IDX > 0;
	localparam bit               HAS_R  = IDX + 1 < CELLS;

	logic [DEG_BITS-1:0] cnt_q;
	logic                pad_q;
	logic                in_range, hit, lower;
	logic [DEG_BITS:0]   nxt;

	assign key      = {pad_q, cnt_q};
	assign in_range = IDX_C < ctrl.active;
	assign hit      = in_range && ((IDX_C == {1'b0, ctrl.vtx_a}) ||
		(!ctrl.directed && IDX_C == {1'b0, ctrl.vtx_b}));
	assign lower    = IDX_ODD == ctrl.phase_odd;

	always_comb begin
		nxt = key;
		if (lower) begin
			if (HAS_R && right_key < key) begin
				nxt = right_key;
			end
		end else begin
			if (HAS_L && left_key > key) begin
				nxt = left_key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pad_q <= 1'b0;
		end else begin
			case (ctrl.mode)
				CM_EDGE: begin
					if (hit && cnt_q != '1) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				CM_PAD: pad_q <= !in_range;
				CM_SORT: {pad_q, cnt_q} <= nxt;
				CM_SHIFT: begin
					if (HAS_R) begin
						{pad_q, cnt_q} <= right_key;
					end else begin
						{pad_q, cnt_q} <= '0;
					end
				end
				CM_CLEAR: begin
					cnt_q <= '0;
					pad_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/graph_degree_sequence_unit.sv
// Graph degree sequence unit: chain of vertex cells, odd-even transposition sort.
// Edge items: one per cycle while idle, no result. Finish item: a pad step + MAX_VERTICES sort
// passes, then one degree per cycle from cell 0 unless m_tready stalls (n items), then a clear step.
// Sort pass count is fixed by the cell chain length. Asynchronous reset clears the
// counters, the output register and sets vertex_count to 32. Depends on gds_pkg, gds_cell.
module graph_degree_sequence_unit import gds_pkg::*; #(
	parameter int MAX_VERTICES = 32,
	parameter int DEGREE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data,   // vertex_count
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [DATA_W-1:0]   s_tdata,       // vertex_a[5:0], vertex_b[11:6], edge_directed[12]
	input  logic                s_tuser,       // opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DATA_W-1:0]   m_tdata,       // degree[15:0]
	output logic                m_tlast        // last_degree
);

	localparam int KW = DEGREE_BITS + 1;
	localparam int PW = $clog2(MAX_VERTICES + 1);
	localparam logic [PW-1:0]    LAST_PASS = PW'(MAX_VERTICES - 1);
	localparam logic [CNT_W-1:0] CELLS_C   = CNT_W'(MAX_VERTICES);

	typedef enum logic [1:0] {ST_IDLE, ST_SORT, ST_EMIT, ST_CLEAR} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    vertex_count_q;
	logic [CNT_W-1:0]    active;
	logic [CNT_W-1:0]    rem_q;
	logic [PW-1:0]       pass_q;
	logic                m_tvalid_q, m_tlast_q;
	logic [DATA_W-1:0]   m_tdata_q;
	logic [DATA_W-1:0]   degree_sat;
	logic                accept, emit;
	logic [VTX_W-1:0]    in_a, in_b;
	cell_ctrl_t          ctrl;
	logic [KW-1:0]       keys [MAX_VERTICES];

	assign in_a    = s_tdata[VTX_W-1:0];
	assign in_b    = s_tdata[2*VTX_W-1:VTX_W];
	assign active  = (vertex_count_q > CELLS_C) ? CELLS_C : vertex_count_q;
	assign s_tready = state_q == ST_IDLE;
	assign accept  = s_tvalid && s_tready;
	assign emit    = state_q == ST_EMIT && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	generate
		if (DEGREE_BITS > DATA_W) begin : g_sat
			assign degree_sat = (keys[0][DEGREE_BITS-1:DATA_W] != '0) ? '1 :
				keys[0][DATA_W-1:0];
		end else begin : g_ext
			assign degree_sat = DATA_W'(keys[0][DEGREE_BITS-1:0]);
		end
	endgenerate

	always_comb begin
		ctrl.mode      = CM_HOLD;
		ctrl.vtx_a     = in_a;
		ctrl.vtx_b     = in_b;
		ctrl.directed  = s_tdata[2*VTX_W];
		ctrl.active    = active;
		ctrl.phase_odd = pass_q[0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser) begin
						ctrl.mode = CM_PAD;
					end else if (in_a != in_b) begin
						ctrl.mode = CM_EDGE;
					end
				end
			end
			ST_SORT:  ctrl.mode = CM_SORT;
			ST_EMIT:  ctrl.mode = emit ? CM_SHIFT : CM_HOLD;
			ST_CLEAR: ctrl.mode = CM_CLEAR;
			default:  ctrl.mode = CM_HOLD;
		endcase
	end

	generate
		for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
			logic [KW-1:0] lk, rk;
			if (i > 0) begin : g_l
				assign lk = keys[i-1];
			end else begin : g_l0
				assign lk = '0;
			end
			if (i + 1 < MAX_VERTICES) begin : g_r
				assign rk = keys[i+1];
			end else begin : g_r0
				assign rk = '0;
			end
			gds_cell #(
				.IDX      (i),
				.CELLS    (MAX_VERTICES),
				.DEG_BITS (DEGREE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.left_key  (lk),
				.right_key (rk),
				.key       (keys[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= CNT_W'(32);
			rem_q          <= '0;
			pass_q         <= '0;
			m_tvalid_q     <= 1'b0;
			m_tlast_q      <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				vertex_count_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready && !emit) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser) begin
						pass_q  <= '0;
						rem_q   <= active;
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == LAST_PASS) begin
						state_q <= (rem_q == '0) ? ST_CLEAR : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= degree_sat;
						m_tlast_q  <= rem_q == CNT_W'(1);
						rem_q      <= rem_q - 1'b1;
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### test/graph_degree_sequence_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for graph_degree_sequence_unit: edge and finish items against a
// sorted-degree predictor, with random stalls on both stream sides.
// Depends on gds_pkg and the graph_degree_sequence_unit RTL.
module graph_degree_sequence_unit_test;
	import gds_pkg::*;

	localparam int MAX_VERTICES  = 32;
	localparam int DEGREE_BITS   = 16;
	localparam int SETTLE_CYCLES = MAX_VERTICES + 16;
	localparam int QUIET_LIMIT   = 1000;
	localparam logic [DEGREE_BITS-1:0] DEGREE_SAT = '1;

	typedef enum logic {
		OP_EDGE   = 1'b0,
		OP_FINISH = 1'b1
	} degree_op_t;

	typedef struct {
		logic [DATA_W-1:0] degree;
		logic              last;
	} degree_result_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data = '0;
	logic              s_tvalid    = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata     = '0;	// vertex_a[5:0], vertex_b[11:6], edge_directed[12]
	logic              s_tuser     = 1'b0;	// opcode
	logic              m_tvalid;
	logic              m_tready    = 1'b0;
	logic [DATA_W-1:0] m_tdata;		// degree[15:0]
	logic              m_tlast;		// last_degree

	degree_result_t         expected_degrees[$];
	logic [DEGREE_BITS-1:0] degree_count [MAX_VERTICES] = '{default: '0};
	logic [CNT_W-1:0]       vertex_count_q = 7'd32;
	int                     idle_max = 4;
	int                     errors = 0;

	graph_degree_sequence_unit #(
		.MAX_VERTICES(MAX_VERTICES),
		.DEGREE_BITS (DEGREE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_vertices();
		return (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_q);
	endfunction

	function automatic void bump_degree(int v);
		if (v < active_vertices() && degree_count[v] != DEGREE_SAT)
			degree_count[v]++;
	endfunction

	function automatic void predict_degrees(degree_op_t op, logic [VTX_W-1:0] a,
			logic [VTX_W-1:0] b, logic dir);
		logic [DEGREE_BITS-1:0] sorted [MAX_VERTICES];
		logic [DEGREE_BITS-1:0] v;
		degree_result_t         r;
		int                     n;
		int                     j;
		if (op == OP_EDGE) begin
			if (a != b) begin
				bump_degree(int'(a));
				if (!dir)
					bump_degree(int'(b));
			end
			return;
		end
		n = active_vertices();
		for (int i = 0; i < n; i++) begin
			v = degree_count[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		for (int i = 0; i < n; i++) begin
			r.degree = (sorted[i] > {DATA_W{1'b1}}) ? '1 : DATA_W'(sorted[i]);
			r.last   = (i == n - 1);
			expected_degrees.push_back(r);
		end
		degree_count = '{default: '0};
	endfunction

	task automatic send_item(degree_op_t op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
			logic dir);
		int   gap;
		logic ready;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= DATA_W'({dir, b, a});
		do begin
			@(negedge clk);
			ready = (s_tready === 1'b1);
			@(posedge clk);
		end while (!ready);
		predict_degrees(op, a, b, dir);
	endtask

	task automatic finish_graph();
		send_item(OP_FINISH, VTX_W'($urandom()), VTX_W'($urandom()), 1'($urandom()));
	endtask

	// drain outstanding degrees, then cover the sort and clear passes of a silent finish
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (expected_degrees.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(logic [CNT_W-1:0] value);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vertex_count_q = value;
	endtask

	task automatic test_default_count();
		send_item(OP_EDGE, 6'd0, 6'd31, 1'b0);
		send_item(OP_EDGE, 6'd31, 6'd32, 1'b0);	// far end out of range
		send_item(OP_EDGE, 6'd63, 6'd5, 1'b1);	// source out of range
		send_item(OP_EDGE, 6'd5, 6'd63, 1'b1);
		send_item(OP_EDGE, 6'd7, 6'd7, 1'b0);	// self-loop
		send_item(OP_EDGE, 6'd40, 6'd40, 1'b1);
		send_item(OP_EDGE, 6'd2, 6'd3, 1'b1);
		send_item(OP_EDGE, 6'd2, 6'd3, 1'b0);
		finish_graph();
		finish_graph();				// counters cleared by the previous finish
	endtask

	task automatic test_count_extremes();
		write_vertex_count(7'd1);
		send_item(OP_EDGE, 6'd0, 6'd1, 1'b0);
		send_item(OP_EDGE, 6'd1, 6'd0, 1'b1);
		finish_graph();
		write_vertex_count(7'd127);		// clamps to depth
		send_item(OP_EDGE, 6'd31, 6'd0, 1'b0);
		send_item(OP_EDGE, 6'd32, 6'd63, 1'b0);
		finish_graph();
		write_vertex_count(7'd64);
		send_item(OP_EDGE, 6'd63, 6'd62, 1'b0);
		send_item(OP_EDGE, 6'd20, 6'd21, 1'b1);
		finish_graph();
		// a finish with no vertices must still clear the counters
		write_vertex_count(7'd32);
		send_item(OP_EDGE, 6'd4, 6'd9, 1'b0);
		send_item(OP_EDGE, 6'd4, 6'd10, 1'b0);
		write_vertex_count(7'd0);
		send_item(OP_EDGE, 6'd1, 6'd2, 1'b0);
		finish_graph();
		write_vertex_count(7'd32);
		finish_graph();
	endtask

	task automatic test_random_graphs();
		int               n_edges;
		int               kind;
		int               span;
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		for (int phase = 0; phase < 7; phase++) begin
			idle_max = (phase % 3 == 1) ? 0 : 4;
			write_vertex_count((phase == 6) ? 7'd127 : CNT_W'($urandom_range(1, 64)));
			span = active_vertices();
			n_edges = $urandom_range(12, 26);
			repeat (n_edges) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					a = VTX_W'($urandom_range(0, span - 1));
					b = VTX_W'($urandom_range(0, span - 1));
				end else if (kind < 9) begin
					a = VTX_W'($urandom());
					b = VTX_W'($urandom());
				end else begin
					a = VTX_W'($urandom());
					b = a;
				end
				send_item(OP_EDGE, a, b, 1'($urandom()));
				if ($urandom_range(0, 11) == 0)
					finish_graph();
			end
			finish_graph();
			if ($urandom_range(0, 3) == 0)
				finish_graph();
		end
		idle_max = 4;
	endtask

	initial begin : degree_sink
		int             gap;
		logic           got;
		logic [DATA_W-1:0] data;
		logic           last;
		degree_result_t want;
		forever begin
			gap = $urandom_range(0, idle_max);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				got  = (m_tvalid === 1'b1);
				data = m_tdata;
				last = m_tlast;
				@(posedge clk);
			end while (!got);
			if (expected_degrees.size() == 0) begin
				errors++;
				$display("%0t: unexpected degree item, expected none, actual %0d last %b",
					$time, data, last);
			end else begin
				want = expected_degrees.pop_front();
				if (data !== want.degree) begin
					errors++;
					$display("%0t: degree mismatch, expected %0d, actual %0d",
						$time, want.degree, data);
				end
				if (last !== want.last) begin
					errors++;
					$display("%0t: last_degree mismatch, expected %b, actual %b",
						$time, want.last, last);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL graph_degree_sequence_unit");
		$finish;
	end

	initial begin : run
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_count();
		test_count_extremes();
		test_random_graphs();
		settle();
		if (errors == 0 && expected_degrees.size() == 0) begin
			$display("PASS graph_degree_sequence_unit");
		end else begin
			$display("FAIL graph_degree_sequence_unit");
		end
		$finish;
	end

endmodule
